// ===== rtl/core/mmc1_pkg.sv =====
// ----------------------------------------------------------------------------
// mmc1_pkg
// Shared types, codes and helpers for the serial-load bank mapper.
// ----------------------------------------------------------------------------
package mmc1_pkg;

  localparam int unsigned OpW      = 2;
  localparam int unsigned AddrW    = 16;
  localparam int unsigned DataW    = 8;
  localparam int unsigned RomAddrW = 18;
  localparam int unsigned SizeW    = 5;
  localparam int unsigned CfgIdxW  = 2;

  // remainder unit: 5-bit bank number, 6-bit bank count
  localparam int unsigned BankW    = 5;
  localparam int unsigned DivW     = 6;
  localparam int unsigned NumSteps = BankW;
  localparam int unsigned StepCntW = $clog2(NumSteps);

  localparam logic [OpW-1:0] OP_CPU_RD = 2'd0;
  localparam logic [OpW-1:0] OP_CPU_WR = 2'd1;
  localparam logic [OpW-1:0] OP_PPU_RD = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_PRG_BANKS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CHR_BANKS = 2'd1;

  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_CHR_LO  = 2'd1;
  localparam logic [1:0] SEL_CHR_HI  = 2'd2;
  localparam logic [1:0] SEL_PRG     = 2'd3;

  // PRG mode, control bits 3:2; the two lower codes both select 32K
  localparam logic [1:0] PRG_FIX_LO = 2'd2;
  localparam logic [1:0] PRG_FIX_HI = 2'd3;

  localparam logic [4:0]       SHIFT_RESET = 5'h10;
  localparam logic [4:0]       CTRL_RESET  = 5'h0C;
  localparam logic [SizeW-1:0] PRG_RESET   = 5'd2;
  localparam logic [SizeW-1:0] CHR_RESET   = 5'd1;
  localparam logic [SizeW-1:0] MaxBanks    = 5'd16;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } in_word_t;

  typedef struct packed {
    logic                maps;
    logic                is_chr;
    logic [RomAddrW-1:0] rom_addr;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic step;
    logic fin;
  } dp_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } ctrl_state_e;

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] n);
    logic [SizeW-1:0] r;
    r = n;
    if (n == '0) r = SizeW'(1);
    else if (n > MaxBanks) r = MaxBanks;
    return r;
  endfunction

endpackage

// ===== rtl/core/mmc1_bank_mapper_core.sv =====
// An accepted word is loaded, put through the remainder steps and registered as result.
// The 5-step bit-serial bank remainder must finish before the next word is accepted.
// The next word is taken while a finished result waits in the output register.
// Reset: asynchronous, active low; size and mapper registers return to defaults.
// ----------------------------------------------------------------------------
// mmc1_bank_mapper_core
// Serial-load bank mapper: register loading and PRG/CHR address translation.
// ----------------------------------------------------------------------------
module mmc1_bank_mapper_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  mmc1_pkg::in_word_t           in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output mmc1_pkg::out_word_t          out_word_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mmc1_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mmc1_pkg::SizeW-1:0]   cfg_data_i
);
  import mmc1_pkg::*;

  dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  mmc1_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  mmc1_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== rtl/core/mmc1_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmc1_ctrl
// Sequencer: accepts a word, runs the remainder steps, hands over the result.
// ----------------------------------------------------------------------------
module mmc1_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mmc1_pkg::dp_cmd_t cmd_o
);
  import mmc1_pkg::*;

  ctrl_state_e         state_q, state_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + StepCntW'(1);
        if (cnt_q == StepCntW'(NumSteps - 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.fin   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/mmc1_datapath.sv =====
// ----------------------------------------------------------------------------
// mmc1_datapath
// Mapper registers, serial loader, bank selection, bit-serial bank remainder
// and output register.
// ----------------------------------------------------------------------------
module mmc1_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mmc1_pkg::dp_cmd_t            cmd_i,
  input  mmc1_pkg::in_word_t           in_word_i,
  input  logic                         cfg_we_i,
  input  logic [mmc1_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mmc1_pkg::SizeW-1:0]   cfg_data_i,
  output mmc1_pkg::out_word_t          out_word_o
);
  import mmc1_pkg::*;

  logic [SizeW-1:0] prg_banks_q, chr_banks_q;
  logic [4:0]       shift_q, ctrl_q, chr_lo_q, chr_hi_q;
  logic [3:0]       prg_sel_q;

  logic             maps_q, is_chr_q;
  logic [13:0]      low_q;
  logic [BankW-1:0] dvd_q;
  logic [DivW-1:0]  div_q, rem_q;
  out_word_t        out_q;

  logic             is_wr, prg_hit, chr_hit;
  logic [SizeW-1:0] prg_n, chr_n;
  logic [3:0]       prg_bank;
  logic [4:0]       chr_bank;
  logic [4:0]       shift_nxt;
  logic [DivW-1:0]  rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_banks_q <= PRG_RESET;
      chr_banks_q <= CHR_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_PRG_BANKS) prg_banks_q <= cfg_data_i;
      if (cfg_index_i == CFG_CHR_BANKS) chr_banks_q <= cfg_data_i;
    end
  end

  assign is_wr     = cmd_i.load && (in_word_i.op == OP_CPU_WR) && in_word_i.addr[15];
  assign shift_nxt = {in_word_i.data[0], shift_q[4:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q   <= SHIFT_RESET;
      ctrl_q    <= CTRL_RESET;
      chr_lo_q  <= '0;
      chr_hi_q  <= '0;
      prg_sel_q <= '0;
    end else if (is_wr) begin
      if (in_word_i.data[7]) begin
        shift_q <= SHIFT_RESET;
        ctrl_q  <= ctrl_q | CTRL_RESET;
      end else if (shift_q[0]) begin
        shift_q <= SHIFT_RESET;
        unique case (in_word_i.addr[14:13])
          SEL_CONTROL: ctrl_q    <= shift_nxt;
          SEL_CHR_LO:  chr_lo_q  <= shift_nxt;
          SEL_CHR_HI:  chr_hi_q  <= shift_nxt;
          SEL_PRG:     prg_sel_q <= shift_nxt[3:0];
          default:     prg_sel_q <= shift_nxt[3:0];
        endcase
      end else begin
        shift_q <= shift_nxt;
      end
    end
  end

  assign prg_n   = clamp_size(prg_banks_q);
  assign chr_n   = clamp_size(chr_banks_q);
  assign prg_hit = (in_word_i.op == OP_CPU_RD) && in_word_i.addr[15];
  assign chr_hit = (in_word_i.op == OP_PPU_RD) && (in_word_i.addr[15:13] == 3'd0);

  always_comb begin
    unique case (ctrl_q[3:2])
      PRG_FIX_LO: prg_bank = in_word_i.addr[14] ? prg_sel_q : 4'd0;
      PRG_FIX_HI: prg_bank = in_word_i.addr[14] ? 4'(prg_n - SizeW'(1)) : prg_sel_q;
      default:    prg_bank = {prg_sel_q[3:1], in_word_i.addr[14]};
    endcase
    if (!ctrl_q[4]) chr_bank = {chr_lo_q[4:1], in_word_i.addr[12]};
    else            chr_bank = in_word_i.addr[12] ? chr_hi_q : chr_lo_q;
  end

  assign rem_sh = {rem_q[DivW-2:0], dvd_q[BankW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      maps_q   <= prg_hit || chr_hit;
      is_chr_q <= chr_hit;
      rem_q    <= '0;
      if (chr_hit) begin
        low_q <= {2'b00, in_word_i.addr[11:0]};
        dvd_q <= chr_bank;
        div_q <= {chr_n, 1'b0};
      end else begin
        low_q <= in_word_i.addr[13:0];
        dvd_q <= {1'b0, prg_bank};
        div_q <= {1'b0, prg_n};
      end
    end else if (cmd_i.step) begin
      dvd_q <= {dvd_q[BankW-2:0], 1'b0};
      rem_q <= (rem_sh >= div_q) ? rem_sh - div_q : rem_sh;
    end
    if (cmd_i.fin) begin
      out_q.maps   <= maps_q;
      out_q.is_chr <= is_chr_q;
      if (!maps_q)       out_q.rom_addr <= '0;
      else if (is_chr_q) out_q.rom_addr <= {1'b0, rem_q[4:0], low_q[11:0]};
      else               out_q.rom_addr <= {rem_q[3:0], low_q};
    end
  end

  assign out_word_o = out_q;

endmodule
